// ===== sv/ibur_pkg.sv =====
package ibur_pkg;

    // Burst framing
    localparam int unsigned BURST_BYTES = 14;
    localparam int unsigned HELD_DEPTH  = BURST_BYTES - 1;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned HELD_IDX_W  = $clog2(HELD_DEPTH);
    localparam logic [POS_W-1:0] POS_DONE = 4'd15;
    localparam logic [POS_W-1:0] LAST_IDX = POS_W'(HELD_DEPTH);

    // Default depth of the sample queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // Temperature conversion: 2500 + round(raw * 20054 / 65536)
    localparam int unsigned     TEMP_W     = 15;
    localparam logic signed [16:0] TEMP_SCALE = 17'sd20054;
    localparam logic signed [31:0] TEMP_HALF  = 32'sd32768;
    localparam logic signed [15:0] TEMP_BASE  = 16'sd2500;

    // Pinned accelerometer code
    localparam logic [15:0] AXIS_PINNED = 16'h8000;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADING_DUMMY = 1'b1;

    // Board rotation codes
    typedef enum logic [1:0] {
        ORIENT_0   = 2'd0,
        ORIENT_90  = 2'd1,
        ORIENT_180 = 2'd2,
        ORIENT_270 = 2'd3
    } orient_t;

    // One raw burst, words as read from the sensor
    typedef struct packed {
        logic [15:0] gz;
        logic [15:0] gy;
        logic [15:0] gx;
        logic [15:0] tr;
        logic [15:0] az;
        logic [15:0] ay;
        logic [15:0] ax;
    } raw_sample_t;

endpackage

// ===== sv/ibur_front.sv =====
module ibur_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                leading_dummy,
    input  logic                byte_take,
    input  logic [7:0]          burst_byte,
    input  logic                burst_start,
    output logic                push,
    output ibur_pkg::raw_sample_t push_data
);
    import ibur_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       held_reg [HELD_DEPTH];

    logic [POS_W-1:0] pos_cur;
    logic [POS_W-1:0] data_idx;
    logic             store;

    // Position of this beat and its data index
    always_comb
    begin
        pos_cur  = burst_start ? '0 : pos_reg;
        data_idx = pos_cur - POS_W'(leading_dummy);
        pos_next = pos_reg;
        store    = 1'b0;
        push     = 1'b0;
        if (byte_take && pos_cur != POS_DONE)
        begin
            if (leading_dummy && pos_cur == '0)
            begin
                pos_next = POS_W'(1);
            end
            else if (data_idx < LAST_IDX)
            begin
                store    = 1'b1;
                pos_next = pos_cur + POS_W'(1);
            end
            else
            begin
                // final data byte completes the sample; anything else ends the burst
                push     = (data_idx == LAST_IDX);
                pos_next = POS_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // Held data bytes
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            held_reg[data_idx[HELD_IDX_W-1:0]] <= burst_byte;
        end
    end

    // Words of the burst, the last low byte straight from the bus
    assign push_data.ax = {held_reg[0],  held_reg[1]};
    assign push_data.ay = {held_reg[2],  held_reg[3]};
    assign push_data.az = {held_reg[4],  held_reg[5]};
    assign push_data.tr = {held_reg[6],  held_reg[7]};
    assign push_data.gx = {held_reg[8],  held_reg[9]};
    assign push_data.gy = {held_reg[10], held_reg[11]};
    assign push_data.gz = {held_reg[12], burst_byte};

endmodule

// ===== sv/ibur_queue.sv =====
module ibur_queue
#(
    parameter int unsigned DEPTH = ibur_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ibur_pkg::raw_sample_t push_data,
    output logic                  full,
    input  logic                  pop,
    output ibur_pkg::raw_sample_t pop_data,
    output logic                  empty
);
    import ibur_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    raw_sample_t       slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/ibur_back.sv =====
module ibur_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ibur_pkg::orient_t     orientation,
    input  logic                  q_empty,
    input  ibur_pkg::raw_sample_t q_data,
    output logic                  q_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [111:0]          m_axis_tdata,  // accel_x, accel_y, accel_z, gyro_x,
                                                 // gyro_y, gyro_z, temp_centideg, pad
    output logic                  m_axis_tuser   // accel_pinned
);
    import ibur_pkg::*;

    // Board rotation of one X/Y pair
    function automatic logic [31:0] rotate_xy(orient_t o, logic [15:0] cx, logic [15:0] cy);
        logic [15:0] ox;
        logic [15:0] oy;
        begin
            unique case (o)
                ORIENT_0:   begin ox = cy;  oy = cx;  end
                ORIENT_90:  begin ox = cx;  oy = ~cy; end
                ORIENT_180: begin ox = ~cy; oy = ~cx; end
                ORIENT_270: begin ox = ~cx; oy = cy;  end
                default:    begin ox = cy;  oy = cx;  end
            endcase
            return {oy, ox};
        end
    endfunction

    // Stage 1: rotation, pinned check and temperature product
    logic               s1_vld_reg;
    logic               s1_vld_next;
    logic [31:0]        s1_acc_xy_reg;
    logic [31:0]        s1_gyr_xy_reg;
    logic [15:0]        s1_az_reg;
    logic [15:0]        s1_gz_reg;
    logic               s1_pinned_reg;
    logic signed [31:0] s1_prod_reg;

    // Stage 2: output register
    logic               out_vld_reg;
    logic               out_vld_next;
    logic [31:0]        out_acc_xy_reg;
    logic [31:0]        out_gyr_xy_reg;
    logic [15:0]        out_az_reg;
    logic [15:0]        out_gz_reg;
    logic [TEMP_W-1:0]  out_temp_reg;
    logic               out_pinned_reg;

    logic               out_load;
    logic               s1_adv;
    logic signed [31:0] temp_sum;
    logic signed [15:0] temp_q;
    logic signed [15:0] temp_c;

    assign out_load = !out_vld_reg || m_axis_tready;
    assign s1_adv   = !s1_vld_reg || out_load;
    assign q_pop    = s1_adv && !q_empty;

    // Round to nearest, halves up, then add the offset
    assign temp_sum = s1_prod_reg + TEMP_HALF;
    assign temp_q   = temp_sum[31:16];
    assign temp_c   = temp_q + TEMP_BASE;

    always_comb
    begin
        s1_vld_next  = s1_adv ? !q_empty : s1_vld_reg;
        out_vld_next = out_load ? s1_vld_reg : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_acc_xy_reg <= rotate_xy(orientation, q_data.ax, q_data.ay);
            s1_gyr_xy_reg <= rotate_xy(orientation, q_data.gx, q_data.gy);
            s1_az_reg     <= ~q_data.az;
            s1_gz_reg     <= ~q_data.gz;
            s1_pinned_reg <= (q_data.ax == AXIS_PINNED) || (q_data.ay == AXIS_PINNED)
                             || (q_data.az == AXIS_PINNED);
            // both operands sign-extended to the product width
            s1_prod_reg   <= 32'(signed'(q_data.tr)) * 32'(TEMP_SCALE);
        end
        if (out_load && s1_vld_reg)
        begin
            out_acc_xy_reg <= s1_acc_xy_reg;
            out_gyr_xy_reg <= s1_gyr_xy_reg;
            out_az_reg     <= s1_az_reg;
            out_gz_reg     <= s1_gz_reg;
            out_temp_reg   <= temp_c[TEMP_W-1:0];
            out_pinned_reg <= s1_pinned_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {1'b0, out_temp_reg, out_gz_reg, out_gyr_xy_reg,
                            out_az_reg, out_acc_xy_reg};
    assign m_axis_tuser  = out_pinned_reg;

endmodule

// ===== sv/imu_burst_unpack_rotate_core.sv =====
// Inertial sensor burst unpacker: takes the 14-byte register burst (accel X/Y/Z,
// temperature, gyro X/Y/Z, each high byte first) one byte per beat on the slave
// stream, with tuser marking the first byte of a burst, and skips one leading
// address-echo byte when leading_dummy is set. The last data byte produces one
// sample on the master stream: X/Y axes rotated per the board orientation, Z axes
// complemented, temperature in centidegrees and a flag for a pinned accel axis.
// Bytes are taken one per cycle, every cycle, as long as the sample queue (two
// entries by default) has room; a sample then passes the queue, the rotate/multiply
// stage and the output register. Configuration is written on cfg_we and
// should only change while no burst is in progress.
module imu_burst_unpack_rotate_core
#(
    parameter int unsigned QUEUE_DEPTH = ibur_pkg::QUEUE_DEPTH
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ibur_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ibur_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // burst_byte
    input  logic                               s_axis_tuser,  // burst_start
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [111:0]                       m_axis_tdata,  // accel_x, accel_y,
                                                              // accel_z, gyro_x, gyro_y,
                                                              // gyro_z, temp_centideg
    output logic                               m_axis_tuser   // accel_pinned
);
    import ibur_pkg::*;

    orient_t     orientation_reg;
    logic        leading_dummy_reg;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    logic        push;
    logic        byte_take;
    raw_sample_t push_data;
    raw_sample_t q_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orientation_reg   <= ORIENT_0;
            leading_dummy_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIENTATION:   orientation_reg   <= orient_t'(cfg_data[1:0]);
                CFG_LEADING_DUMMY: leading_dummy_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign byte_take     = s_axis_tvalid && s_axis_tready;

    ibur_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .leading_dummy (leading_dummy_reg),
        .byte_take     (byte_take),
        .burst_byte    (s_axis_tdata),
        .burst_start   (s_axis_tuser),
        .push          (push),
        .push_data     (push_data)
    );

    ibur_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    ibur_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .orientation   (orientation_reg),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
